// ===== hdl/zie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Z-machine instruction encoder package
// Shared types, codes and sizes for the encoder lanes, merge and output stage.
// ----------------------------------------------------------------------------
package zie_pkg;

  // Operand slots carried by one request word
  localparam int MAX_OPERANDS = 4;
  localparam int NUM_LANES    = 4;
  localparam int CNT_W        = 3;

  // Longest encoding: opcode, type byte, four large constants
  localparam int MAX_BYTES = 2 + 2 * NUM_LANES;
  localparam int FRAME_W   = 8 * MAX_BYTES;
  localparam int LEN_W     = $clog2(MAX_BYTES + 1);

  // Input word layout
  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = 2;

  // Form selector
  typedef enum logic [1:0] {
    FORM_ONE  = 2'd0,
    FORM_TWO  = 2'd1,
    FORM_VAR  = 2'd2,
    FORM_NONE = 2'd3
  } form_t;

  // Operand type codes as they appear in the type byte
  typedef enum logic [1:0] {
    KIND_LARGE = 2'd0,
    KIND_SMALL = 2'd1,
    KIND_VAR   = 2'd2,
    KIND_OMIT  = 2'd3
  } kind_t;

  // Per-operand classification from one lane
  typedef struct packed {
    kind_t       kind;
    logic        big;     // value does not fit in a byte
    logic [1:0]  nbytes;  // operand bytes when emitted
    logic [15:0] bytes;   // first emitted byte in the low half
  } lane_res_t;

  // One encoded instruction, byte 0 in the low bits
  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [FRAME_W-1:0] bytes;
  } frame_t;

endpackage

// ===== hdl/zmachine_instruction_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Z-machine instruction encoder core
// Four operand lanes classify the operands in parallel, a merge stage packs
// the encoding, and a serializer streams it out one byte per word.
// ----------------------------------------------------------------------------
// The request passes the waiting, in-flight and output registers before m_tvalid.
// Throughput: one output byte per cycle while m_tready is high; an instruction
//   of n bytes (2 to 10) takes n words, and the next request is taken while it is sent.
// Requests with form 3 are accepted and produce no bytes.
// Reset: synchronous, active high; clears all valid flags, nothing in flight.
// ----------------------------------------------------------------------------
module zmachine_instruction_encoder_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [7:0] opcode_bits, [10:8] operand_count, [26:11] operand_a,
  // [42:27] operand_b, [58:43] operand_c, [74:59] operand_d,
  // [75] a_is_variable, [76] b_is_variable, [77] c_is_variable,
  // [78] d_is_variable, [79] zero
  input  logic [zie_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [zie_pkg::S_TUSER_W-1:0]   s_tuser,  // [1:0] form
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,  // [7:0] code_byte
  output logic                            m_tlast   // last_byte
);
  import zie_pkg::*;

  logic [15:0]          opnd     [NUM_LANES];
  logic [NUM_LANES-1:0] lane_var;
  lane_res_t            lanes    [NUM_LANES];
  frame_t               frame;
  form_t                form;

  // Unpack the request word
  assign form = form_t'(s_tuser[1:0]);
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      opnd[i]     = s_tdata[11 + 16*i +: 16];
      lane_var[i] = s_tdata[75 + i];
    end
  end

  // Operand lanes
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    zie_lane u_lane (
      .value  (opnd[g]),
      .is_var (lane_var[g]),
      .res    (lanes[g])
    );
  end

  // Form decode and byte packing
  zie_merge u_merge (
    .form          (form),
    .opcode_bits   (s_tdata[7:0]),
    .operand_count (s_tdata[10:8]),
    .lanes         (lanes),
    .lane_var      (lane_var),
    .frame         (frame)
  );

  // Output stream
  zie_serializer u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_frame (frame),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hdl/zie_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder operand lane
// Classifies one operand and lays out the bytes it would emit.
// ----------------------------------------------------------------------------
module zie_lane (
  input  logic                [15:0] value,
  input  logic                       is_var,
  output zie_pkg::lane_res_t         res
);
  import zie_pkg::*;

  logic big;

  assign big = (value[15:8] != 8'd0);

  // Variable flag wins; otherwise the value size picks small or large
  always_comb begin
    res.big = big;
    if (is_var) begin
      res.kind   = KIND_VAR;
      res.nbytes = 2'd1;
      res.bytes  = {8'd0, value[7:0]};
    end else if (big) begin
      res.kind   = KIND_LARGE;
      res.nbytes = 2'd2;
      res.bytes  = {value[7:0], value[15:8]};  // high byte goes first
    end else begin
      res.kind   = KIND_SMALL;
      res.nbytes = 2'd1;
      res.bytes  = {8'd0, value[7:0]};
    end
  end

endmodule

// ===== hdl/zie_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder merge stage
// Picks the instruction form and packs opcode, type byte and lane bytes.
// ----------------------------------------------------------------------------
module zie_merge (
  input  zie_pkg::form_t                   form,
  input  logic                       [7:0] opcode_bits,
  input  logic      [zie_pkg::CNT_W-1:0]   operand_count,
  input  zie_pkg::lane_res_t               lanes [zie_pkg::NUM_LANES],
  input  logic [zie_pkg::NUM_LANES-1:0]    lane_var,
  output zie_pkg::frame_t                  frame
);
  import zie_pkg::*;

  localparam int SH_W = $clog2(FRAME_W);

  logic [CNT_W-1:0]     cnt_sat;
  logic [NUM_LANES-1:0] en;
  logic                 has_type;
  logic                 any_big;
  logic [7:0]           hdr;
  logic [7:0]           tbyte;
  logic [LEN_W-1:0]     off;
  logic [FRAME_W-1:0]   vec;

  assign any_big = lanes[0].big | lanes[1].big;
  assign cnt_sat = (operand_count > CNT_W'(MAX_OPERANDS)) ? CNT_W'(MAX_OPERANDS)
                                                           : operand_count;

  // Form decode: opcode byte, lane enables, type byte presence
  always_comb begin
    hdr      = 8'd0;
    en       = '0;
    has_type = 1'b0;
    unique case (form)
      FORM_ONE: begin
        hdr = {2'b10, lanes[0].kind, opcode_bits[3:0]};
        en  = NUM_LANES'(1);
      end
      FORM_TWO: begin
        en = NUM_LANES'(3);
        if (any_big) begin
          hdr      = {3'b110, opcode_bits[4:0]};
          has_type = 1'b1;
        end else begin
          hdr = {1'b0, lane_var[0], lane_var[1], opcode_bits[4:0]};
        end
      end
      FORM_VAR: begin
        hdr      = {2'b11, (opcode_bits[7:6] != 2'b00), opcode_bits[4:0]};
        has_type = 1'b1;
        for (int i = 0; i < NUM_LANES; i++) begin
          en[i] = (CNT_W'(i) < cnt_sat);
        end
      end
      FORM_NONE: begin
        hdr = 8'd0;
      end
      default: begin
        hdr = 8'd0;
      end
    endcase
  end

  // Type byte, slot 0 in the top bits; disabled slots are omitted
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      tbyte[7-2*i -: 2] = en[i] ? lanes[i].kind : KIND_OMIT;
    end
  end

  // Pack lane bytes behind the opcode and type byte
  always_comb begin
    vec = FRAME_W'(hdr);
    if (has_type) begin
      vec = vec | (FRAME_W'(tbyte) << 8);
    end
    off = has_type ? LEN_W'(2) : LEN_W'(1);
    for (int i = 0; i < NUM_LANES; i++) begin
      if (en[i]) begin
        vec = vec | (FRAME_W'(lanes[i].bytes) << {SH_W'(off), 3'b000});
        off = off + LEN_W'(lanes[i].nbytes);
      end
    end
    frame.bytes = vec;
    frame.len   = (form == FORM_NONE) ? LEN_W'(0) : off;
  end

endmodule

// ===== hdl/zie_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder byte serializer
// Holds one encoded frame in waiting and one in flight, and sends bytes
// through a registered output word with tlast on the final byte.
// ----------------------------------------------------------------------------
module zie_serializer (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  zie_pkg::frame_t in_frame,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // [7:0] code_byte
  output logic            m_tlast    // last_byte
);
  import zie_pkg::*;

  // Waiting frame
  logic               pv;
  logic [FRAME_W-1:0] pbytes;
  logic [LEN_W-1:0]   plen;
  // Frame in flight
  logic               cv;
  logic [FRAME_W-1:0] cbytes;
  logic [LEN_W-1:0]   crem;

  logic out_load, emit, cur_done, cur_free, take_p, keep_in;

  assign out_load = !m_tvalid || m_tready;
  assign emit     = cv && out_load;
  assign cur_done = emit && (crem == LEN_W'(1));
  assign cur_free = !cv || cur_done;
  assign take_p   = pv && cur_free;
  assign in_ready = !pv || take_p;
  // Frames with no bytes are dropped at the door
  assign keep_in  = in_valid && in_ready && (in_frame.len != '0);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      pv       <= 1'b0;
      cv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pv <= keep_in || (pv && !take_p);
      if (take_p) begin
        cv <= 1'b1;
      end else if (cur_done) begin
        cv <= 1'b0;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (keep_in) begin
      pbytes <= in_frame.bytes;
      plen   <= in_frame.len;
    end
    if (take_p) begin
      cbytes <= pbytes;
      crem   <= plen;
    end else if (emit) begin
      cbytes <= cbytes >> 8;
      crem   <= crem - LEN_W'(1);
    end
    if (emit) begin
      m_tdata <= cbytes[7:0];
      m_tlast <= (crem == LEN_W'(1));
    end
  end

endmodule

// ===== hdl/zie_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder port checker
// Watches the top-level ports for output holding, idle after reset and instruction length.
// ----------------------------------------------------------------------------
module zie_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [7:0]                    m_tdata,
  input logic                          m_tlast
);
  import zie_pkg::*;

  // Bytes already sent in the current instruction
  logic [LEN_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (m_tvalid && m_tready) begin
      cnt <= m_tlast ? LEN_W'(0) : cnt + LEN_W'(1);
    end
  end

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // Nothing pending out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // An instruction never exceeds the longest encoding
  a_max_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt < LEN_W'(MAX_BYTES))
    else $error("instruction longer than the longest encoding");

  // Every instruction has an opcode byte and at least one more byte
  a_min_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> cnt != LEN_W'(0))
    else $error("instruction ended on its first byte");

endmodule

bind zmachine_instruction_encoder_core zie_checker u_zie_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
